// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the top-level averaging unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define MPE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Check that one condition implies another in the same cycle.
`define MPE_ASSERT_IMPLY(name, clk, rst_n, lhs, rhs) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("%m: implication failed");

`endif

// File: sv/mpema_pkg.sv
// ----------------------------------------------------------------------------
// mpema_pkg
// Shared constants, types and tables of the multi-period averaging unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mpema_pkg;

  // Default parameter values.
  localparam int NUM_FILTERS_DEF = 5;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int PERIOD_W   = 8;
  localparam int COUNT_W    = 8;
  localparam int DEN_W      = PERIOD_W + 1;
  localparam int SEL_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_W      = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SELECT = 3'd0;
  localparam int REG_PERIOD_BASE = 1;
  localparam int NUM_PERIOD_REGS = 5;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Period reset values by filter.
  function automatic logic [PERIOD_W-1:0] period_reset(input logic [2:0] idx);
    logic [PERIOD_W-1:0] val;
    unique case (idx)
      3'd0:    val = 8'd5;
      3'd1:    val = 8'd10;
      3'd2:    val = 8'd15;
      3'd3:    val = 8'd30;
      default: val = 8'd50;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: sv/mpema_ram.sv
// ----------------------------------------------------------------------------
// mpema_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpema_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 5,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/mpema_div.sv
// ----------------------------------------------------------------------------
// mpema_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpema_div #(
  parameter int DIV_W = 33
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [DIV_W-1:0]            dividend_i,
  input  wire logic [mpema_pkg::DEN_W-1:0] divisor_i,
  output logic      [DIV_W-1:0]            quotient_o,
  output mpema_pkg::div_stat_t             stat_o
);

  import mpema_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             borrow;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
  assign borrow  = trial[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift one dividend bit into the partial remainder each step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      if (borrow) begin
        rem_q <= shifted[DEN_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end else begin
        rem_q <= trial[DEN_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// File: sv/multi_period_ema_with_warmup_unit.sv
// ----------------------------------------------------------------------------
// multi_period_ema_with_warmup_unit
// Bank of averaging filters with cumulative-mean warm-up and EMA tracking.
// ----------------------------------------------------------------------------
// Sequence: each filter in turn reads its entry, sets up the step, runs the
//   shared divider, which retires one quotient bit per cycle, and writes back.
//   The selected filter's result is then registered for output. A new request
//   is accepted only while idle, once the previous one has left the sequencer.
// Reset: averages and counts read as zero through per-entry valid flags, so
//   no clearing pass runs; periods return to 5, 10, 15, 30, 50, select to 0.
`default_nettype none

`include "assert_macros.svh"

module multi_period_ema_with_warmup_unit #(
  parameter int NUM_FILTERS = mpema_pkg::NUM_FILTERS_DEF,
  parameter int SAMPLE_BITS = mpema_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = mpema_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [mpema_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mpema_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Sample request channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]           sample_value_i,
  // Result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [mpema_pkg::OUT_W-1:0]      average_value_o,
  output logic                                  warmed_up_o
);

  import mpema_pkg::*;

  localparam int AVG_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int DIV_W    = AVG_BITS + 1;
  localparam int MEM_W    = COUNT_W + AVG_BITS;
  localparam int IDX_W    = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

  // Per-filter sequencer: read entry, set up the step, divide, write back.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_WRITE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [SEL_W-1:0]    sel_q;
  logic [PERIOD_W-1:0] period_q [NUM_FILTERS];

  // Sequencer registers
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [NUM_FILTERS-1:0] ent_valid_q;
  logic                   rd_valid_q;
  logic [AVG_BITS-1:0]    avg_old_q;
  logic                   up_q;
  logic [COUNT_W-1:0]     k_q;
  logic                   warm_q;
  logic [AVG_BITS-1:0]    pend_avg_q;
  logic                   pend_warm_q;

  // Result registers
  logic             out_valid_q;
  logic [OUT_W-1:0] out_avg_q;
  logic             out_warm_q;

  // Memory and divider hookup
  logic                 mem_we;
  logic                 mem_re;
  logic [MEM_W-1:0]     mem_wdata;
  logic [MEM_W-1:0]     mem_rdata;
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DEN_W-1:0]     div_divisor;
  logic [DIV_W-1:0]     div_quotient;
  div_stat_t            div_stat;

  // Step set-up
  logic [AVG_BITS-1:0]    x_w;
  logic [AVG_BITS-1:0]    rd_avg;
  logic [COUNT_W-1:0]     rd_cnt;
  logic [PERIOD_W-1:0]    n_w;
  logic [DEN_W-1:0]       k_full;
  logic [DEN_W-1:0]       k_w;
  logic                   cum_w;
  logic                   up_w;
  logic [AVG_BITS-1:0]    diff_w;
  logic [AVG_BITS-1:0]    new_avg;
  logic [IDX_W-1:0]       sel_eff;
  logic                   in_accept;
  logic                   out_load;
  logic [OUT_W+AVG_BITS-1:0] avg_pad;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Select values past the last filter report filter 0.
  assign sel_eff = ({1'b0, sel_q} >= (SEL_W+1)'(NUM_FILTERS)) ? '0 : IDX_W'(sel_q);

  // Configuration writes; indexes past the list drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
      for (int i = 0; i < NUM_FILTERS; i++) begin
        period_q[i] <= period_reset(3'(i));
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_SELECT) begin
        sel_q <= cfg_data_i[SEL_W-1:0];
      end
      for (int i = 0; i < NUM_FILTERS; i++) begin
        if (i < NUM_PERIOD_REGS &&
            {1'b0, cfg_index_i} == (CFG_IDX_W+1)'(REG_PERIOD_BASE + i)) begin
          period_q[i] <= cfg_data_i[PERIOD_W-1:0];
        end
      end
    end
  end

  // Unwritten entries read as zero average and zero count.
  assign rd_avg = rd_valid_q ? mem_rdata[AVG_BITS-1:0] : '0;
  assign rd_cnt = rd_valid_q ? mem_rdata[MEM_W-1:AVG_BITS] : '0;
  assign x_w    = {sample_q, {FRAC_BITS{1'b0}}};

  // A zero period acts as period one; the count saturates at the period.
  assign n_w    = (period_q[idx_q] == '0) ? PERIOD_W'(1) : period_q[idx_q];
  assign k_full = {1'b0, rd_cnt} + DEN_W'(1);
  assign k_w    = (k_full > {1'b0, n_w}) ? {1'b0, n_w} : k_full;
  assign cum_w  = (k_w < {1'b0, n_w});
  assign up_w   = (x_w >= rd_avg);
  assign diff_w = up_w ? (x_w - rd_avg) : (rd_avg - x_w);

  // Cumulative mean divides diff by k; the EMA divides 2 * diff by N + 1.
  assign div_start    = (state_q == ST_LOAD);
  assign div_dividend = cum_w ? {1'b0, diff_w} : {diff_w, 1'b0};
  assign div_divisor  = cum_w ? k_w : ({1'b0, n_w} + DEN_W'(1));

  // The step never exceeds the distance to the sample, so no wrap occurs.
  assign new_avg = up_q ? (avg_old_q + div_quotient[AVG_BITS-1:0])
                        : (avg_old_q - div_quotient[AVG_BITS-1:0]);

  assign mem_re    = (state_q == ST_READ);
  assign mem_we    = (state_q == ST_WRITE);
  assign mem_wdata = {k_q, new_avg};

  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_READ;
          idx_d   = '0;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (idx_q == IDX_W'(NUM_FILTERS - 1)) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_READ;
          idx_d   = idx_q + 1'b1;
        end
      end
      ST_FINISH: begin
        // Hold until the result register is free.
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      ent_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (mem_re) begin
        rd_valid_q <= ent_valid_q[idx_q];
      end
      if (mem_we) begin
        ent_valid_q[idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign avg_pad = {{OUT_W{1'b0}}, pend_avg_q};

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_value_i;
    end
    if (state_q == ST_LOAD) begin
      avg_old_q <= rd_avg;
      up_q      <= up_w;
      k_q       <= k_w[COUNT_W-1:0];
      warm_q    <= !cum_w;
    end
    if (mem_we && (idx_q == sel_eff)) begin
      pend_avg_q  <= new_avg;
      pend_warm_q <= warm_q;
    end
    if (out_load) begin
      out_avg_q  <= avg_pad[OUT_W-1:0];
      out_warm_q <= pend_warm_q;
    end
  end

  mpema_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_FILTERS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  mpema_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .stat_o     (div_stat)
  );

  assign out_valid_o     = out_valid_q;
  assign average_value_o = out_avg_q;
  assign warmed_up_o     = out_warm_q;

  // Read and write-back of the state memory never share a cycle.
  `MPE_ASSERT(a_no_rw_overlap, clk_i, rst_ni, !(mem_we && mem_re))
  // A quotient only completes while the sequencer waits for it.
  `MPE_ASSERT_IMPLY(a_div_done_in_div, clk_i, rst_ni, div_stat.done, state_q == ST_DIV)
  // A new result only appears out of the final state.
  `MPE_ASSERT(a_out_from_finish, clk_i, rst_ni,
              $rose(out_valid_o) |-> $past(state_q == ST_FINISH))

endmodule

`default_nettype wire
